[design/contiguous_fit_allocator_defines.svh]
// assertion macros used by the allocator top level
`ifndef CONTIGUOUS_FIT_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// clocked assertion with an explicit clock and reset
`define CFA_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion on the default clock and reset names
`define CFA_ASSERT(lbl, prop, msg) \
   `CFA_ASSERT_CLK(lbl, clock, reset, prop, msg)

`else

`define CFA_ASSERT_CLK(lbl, clk, rst, prop, msg)
`define CFA_ASSERT(lbl, prop, msg)

`endif

`endif

[design/cfa_pkg.sv]
// types and constants of the contiguous fit allocator
package cfa_pkg;

   localparam int CMD_W    = 2;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 3;
   localparam int AMT_W    = 21;

   localparam logic [AMT_W-1:0] TOTAL_RESET = AMT_W'(1048576);

   // commands
   localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPACT = 2'd2;

   // fit modes
   localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOFIT   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BADMODE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOOWNER = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_PLACE,
      S_RELEASE,
      S_COMPACT,
      S_FINISH
   } state_type;

endpackage

[design/cfa_ram.sv]
// generic single write port, single read port ram with registered read
module cfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/contiguous_fit_allocator.sv]
// contiguous fit allocator top level: sequencer, region table and result register
//
// contiguous memory allocator over a region of csr total_size units (clamped to
// 2**ADDR_BITS). a table of up to MAX_REGIONS allocated regions (base, size, owner)
// is kept in address order in a small ram; the holes are the gaps before the first
// region, between regions and up to the total. an allocation request places its
// block at the start of the hole chosen by fit mode (first, best or worst fit,
// earliest on ties), a release drops every region of the owner and a compaction
// slides all regions down so that no gaps remain. every request gives exactly one
// response. the table ram has one read and one write port and every step of the
// sequencer handles one table entry: an allocation scans the holes, shifts the
// entries above the chosen slot up, places the new entry and writes the result;
// a release or a compaction walks the table once and a rejected request goes
// straight to the result. the block takes a new request only when the sequencer
// is idle, while a finished response may still be waiting in the output register.
// no clearing pass is needed after reset.
`include "contiguous_fit_allocator_defines.svh"

module contiguous_fit_allocator #(
   parameter int MAX_REGIONS = 16,
   parameter int ADDR_BITS   = 20,
   parameter int OWNER_BITS  = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [cfa_pkg::AMT_W-1:0]           csr_wr_data,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [cfa_pkg::CMD_W-1:0]           req_cmd,
   input  logic [OWNER_BITS-1:0]               req_owner_id,
   input  logic [cfa_pkg::AMT_W-1:0]           req_amount,
   input  logic [cfa_pkg::MODE_W-1:0]          req_fit_mode,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_ok,
   output logic [cfa_pkg::STATUS_W-1:0]        rsp_status,
   output logic [ADDR_BITS-1:0]                rsp_granted_base,
   output logic [$clog2(MAX_REGIONS+1)-1:0]    rsp_freed_count
);

   import cfa_pkg::*;

   // index wide enough to hold the region count itself
   localparam int IDX_W   = $clog2(MAX_REGIONS + 1);
   localparam int AW      = $clog2(MAX_REGIONS);
   localparam int ENTRY_W = ADDR_BITS + AMT_W + OWNER_BITS;
   // hole ends are base + size, one bit above the wider of the two
   localparam int SUM_W   = ((ADDR_BITS > AMT_W) ? ADDR_BITS : AMT_W) + 1;
   localparam logic [SUM_W-1:0] SPAN = SUM_W'(1) << ADDR_BITS;

   // control state
   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  count_ff, count_in;
   logic [AMT_W-1:0]  total_size_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   // request held while the sequencer works
   logic [OWNER_BITS-1:0] owner_ff, owner_in;
   logic [AMT_W-1:0]      amount_ff, amount_in;
   logic [MODE_W-1:0]     mode_ff, mode_in;

   // sequencer datapath
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     wp_ff, wp_in;        // release write pointer
   logic [SUM_W-1:0]     prev_end_ff, prev_end_in;
   logic                 found_ff;
   logic [SUM_W-1:0]     pv_ff;
   logic [IDX_W-1:0]     pick_ff;
   logic [ADDR_BITS-1:0] start_ff;
   logic [ADDR_BITS-1:0] next_ff, next_in;    // compaction fill address

   // result waiting for the output register
   logic                 res_ok_ff, res_ok_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [ADDR_BITS-1:0] res_base_ff, res_base_in;
   logic [IDX_W-1:0]     res_freed_ff, res_freed_in;

   // output register
   logic                 rsp_ok_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [ADDR_BITS-1:0] rsp_base_ff;
   logic [IDX_W-1:0]     rsp_freed_ff;

   // table ram
   logic               ram_we;
   logic [AW-1:0]      ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic [AW-1:0]      ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;

   logic [ADDR_BITS-1:0]  rd_base;
   logic [AMT_W-1:0]      rd_size;
   logic [OWNER_BITS-1:0] rd_owner;

   // hole evaluation unit
   logic                 accept;
   logic                 out_load;
   logic [IDX_W-1:0]     idx_inc;
   logic [IDX_W-1:0]     idx_dec;
   logic [SUM_W-1:0]     eff_total;
   logic [SUM_W-1:0]     hole_end;
   logic [SUM_W-1:0]     hole_size;
   logic                 hole_fits;
   logic                 take;
   logic                 found_nx;
   logic [SUM_W-1:0]     pv_nx;
   logic [IDX_W-1:0]     pick_nx;
   logic [ADDR_BITS-1:0] start_nx;
   logic                 scan_last;
   logic                 scan_done;
   logic                 scan_ok;
   logic                 shift_done;
   logic                 seq_last;
   logic                 rel_match;
   logic                 mode_bad;
   logic                 table_full;

   cfa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_REGIONS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_base  = ram_rd_data[ENTRY_W-1 -: ADDR_BITS];
   assign rd_size  = ram_rd_data[AMT_W+OWNER_BITS-1 -: AMT_W];
   assign rd_owner = ram_rd_data[OWNER_BITS-1:0];

   assign accept     = req_valid && (state_ff == S_IDLE);
   assign req_stall  = (state_ff != S_IDLE);
   assign out_load   = (state_ff == S_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign idx_inc    = idx_ff + IDX_W'(1);
   assign idx_dec    = idx_ff - IDX_W'(1);
   assign mode_bad   = (req_fit_mode != MODE_FIRST) && (req_fit_mode != MODE_BEST) &&
                       (req_fit_mode != MODE_WORST);
   assign table_full = (count_ff >= IDX_W'(MAX_REGIONS));

   // total clamped to the address span
   assign eff_total = (SUM_W'(total_size_ff) > SPAN) ? SPAN : SUM_W'(total_size_ff);

   // hole idx runs from the end of the previous region to this region's base,
   // the last hole up to the total; a hole that ends below its start is empty
   assign scan_last = (idx_ff == count_ff);
   assign hole_end  = scan_last ? eff_total : SUM_W'(rd_base);
   assign hole_size = (hole_end > prev_end_ff) ? (hole_end - prev_end_ff) : '0;
   assign hole_fits = (hole_size >= SUM_W'(amount_ff));

   always_comb begin
      case (mode_ff)
         MODE_FIRST: take = hole_fits && !found_ff;
         MODE_BEST:  take = hole_fits && (!found_ff || (hole_size < pv_ff));
         default:    take = !found_ff || (hole_size > pv_ff);
      endcase
   end

   assign found_nx  = found_ff || take;
   assign pv_nx     = take ? hole_size : pv_ff;
   assign pick_nx   = take ? idx_ff : pick_ff;
   assign start_nx  = take ? prev_end_ff[ADDR_BITS-1:0] : start_ff;
   assign scan_done = scan_last || ((mode_ff == MODE_FIRST) && hole_fits);
   // worst fit keeps the largest hole and only then checks it against the amount
   assign scan_ok   = found_nx && ((mode_ff != MODE_WORST) || (pv_nx >= SUM_W'(amount_ff)));

   // shifting ends once the entry at the chosen slot has moved up
   assign shift_done = (idx_dec == pick_ff);
   assign seq_last   = (idx_inc == count_ff);
   assign rel_match  = (rd_owner == owner_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_ALLOC: begin
                     if (mode_bad || table_full || (req_amount == '0)) begin
                        state_in = S_FINISH;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  CMD_RELEASE: state_in = (count_ff == '0) ? S_FINISH : S_RELEASE;
                  CMD_COMPACT: state_in = (count_ff == '0) ? S_FINISH : S_COMPACT;
                  default:     state_in = S_FINISH;
               endcase
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               if (!scan_ok) begin
                  state_in = S_FINISH;
               end else if (pick_nx == count_ff) begin
                  state_in = S_PLACE;
               end else begin
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT:   state_in = shift_done ? S_PLACE : S_SHIFT;
         S_PLACE:   state_in = S_FINISH;
         S_RELEASE: state_in = seq_last ? S_FINISH : S_RELEASE;
         S_COMPACT: state_in = seq_last ? S_FINISH : S_COMPACT;
         S_FINISH:  state_in = out_load ? S_IDLE : S_FINISH;
         default:   state_in = S_IDLE;
      endcase
   end

   // datapath and ram control
   always_comb begin
      count_in      = count_ff;
      owner_in      = owner_ff;
      amount_in     = amount_ff;
      mode_in       = mode_ff;
      idx_in        = idx_ff;
      wp_in         = wp_ff;
      prev_end_in   = prev_end_ff;
      next_in       = next_ff;
      res_ok_in     = res_ok_ff;
      res_status_in = res_status_ff;
      res_base_in   = res_base_ff;
      res_freed_in  = res_freed_ff;
      ram_we        = 1'b0;
      ram_wr_addr   = idx_ff[AW-1:0];
      ram_wr_data   = ram_rd_data;
      ram_rd_addr   = idx_inc[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            ram_rd_addr = '0;
            if (accept) begin
               owner_in      = req_owner_id;
               amount_in     = req_amount;
               mode_in       = req_fit_mode;
               idx_in        = '0;
               wp_in         = '0;
               prev_end_in   = '0;
               next_in       = '0;
               res_ok_in     = 1'b0;
               res_status_in = ST_DONE;
               res_base_in   = '0;
               res_freed_in  = '0;
               case (req_cmd)
                  CMD_ALLOC: begin
                     if (mode_bad) begin
                        res_status_in = ST_BADMODE;
                     end else if (table_full) begin
                        res_status_in = ST_FULL;
                     end else if (req_amount == '0) begin
                        res_status_in = ST_NOFIT;
                     end
                  end
                  CMD_RELEASE: res_status_in = ST_NOOWNER;
                  CMD_COMPACT: res_ok_in = 1'b1;
                  default:     res_status_in = ST_BADMODE;
               endcase
            end
         end
         S_SCAN: begin
            prev_end_in = SUM_W'(rd_base) + SUM_W'(rd_size);
            if (scan_done) begin
               // move the top entry first
               idx_in      = count_ff;
               ram_rd_addr = idx_dec[AW-1:0];
               ram_rd_addr = AW'(count_ff - IDX_W'(1));
               if (!scan_ok) begin
                  res_status_in = ST_NOFIT;
               end
            end else begin
               idx_in = idx_inc;
            end
         end
         S_SHIFT: begin
            ram_we      = 1'b1;
            ram_wr_addr = idx_ff[AW-1:0];
            ram_wr_data = ram_rd_data;
            idx_in      = idx_dec;
            ram_rd_addr = AW'(idx_ff - IDX_W'(2));
         end
         S_PLACE: begin
            ram_we      = 1'b1;
            ram_wr_addr = pick_ff[AW-1:0];
            ram_wr_data = {start_ff, amount_ff, owner_ff};
            count_in    = count_ff + IDX_W'(1);
            res_ok_in   = 1'b1;
            res_base_in = start_ff;
         end
         S_RELEASE: begin
            if (rel_match) begin
               res_freed_in = res_freed_ff + IDX_W'(1);
            end else begin
               ram_we      = 1'b1;
               ram_wr_addr = wp_ff[AW-1:0];
               ram_wr_data = ram_rd_data;
               wp_in       = wp_ff + IDX_W'(1);
            end
            idx_in = idx_inc;
            if (seq_last) begin
               count_in = wp_in;
               if (res_freed_in != '0) begin
                  res_ok_in     = 1'b1;
                  res_status_in = ST_DONE;
               end
            end
         end
         S_COMPACT: begin
            ram_we      = 1'b1;
            ram_wr_addr = idx_ff[AW-1:0];
            ram_wr_data = {next_ff, rd_size, rd_owner};
            next_in     = ADDR_BITS'(SUM_W'(next_ff) + SUM_W'(rd_size));
            idx_in      = idx_inc;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // response register: loads when empty or being taken
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         total_size_ff <= TOTAL_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            total_size_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      owner_ff      <= owner_in;
      amount_ff     <= amount_in;
      mode_ff       <= mode_in;
      idx_ff        <= idx_in;
      wp_ff         <= wp_in;
      prev_end_ff   <= prev_end_in;
      next_ff       <= next_in;
      res_ok_ff     <= res_ok_in;
      res_status_ff <= res_status_in;
      res_base_ff   <= res_base_in;
      res_freed_ff  <= res_freed_in;
      // best candidate so far, cleared for every new request
      if (accept) begin
         found_ff <= 1'b0;
         pv_ff    <= '0;
         pick_ff  <= '0;
         start_ff <= '0;
      end else if (state_ff == S_SCAN) begin
         found_ff <= found_nx;
         pv_ff    <= pv_nx;
         pick_ff  <= pick_nx;
         start_ff <= start_nx;
      end
      if (out_load) begin
         rsp_ok_ff     <= res_ok_ff;
         rsp_status_ff <= res_status_ff;
         rsp_base_ff   <= res_base_ff;
         rsp_freed_ff  <= res_freed_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_base = rsp_base_ff;
   assign rsp_freed_count  = rsp_freed_ff;

   // checks
   `CFA_ASSERT(a_count_range, count_ff <= IDX_W'(MAX_REGIONS), "region count out of range")
   `CFA_ASSERT(a_shift_above_pick, (state_ff == S_SHIFT) |-> (idx_ff > pick_ff), "shift below slot")
   `CFA_ASSERT(a_place_grows, (state_ff == S_PLACE) |=> (count_ff == $past(count_ff) + IDX_W'(1)), "placement did not grow table")
   `CFA_ASSERT(a_ok_is_done, rsp_valid_ff |-> (!rsp_ok_ff || (rsp_status_ff == ST_DONE)), "ok with error status")
   `CFA_ASSERT(a_write_in_work, ram_we |-> ((state_ff != S_IDLE) && (state_ff != S_SCAN) && (state_ff != S_FINISH)), "table written outside work")

endmodule

[tb/sv/tb_top.sv]
// testbench for the contiguous fit allocator: predictor, scoreboard, stimulus and checks
`timescale 1ns / 100ps

module tb_top;
   import cfa_pkg::*;

   localparam int MAX_REGIONS  = 16;
   localparam int ADDR_BITS    = 20;
   localparam int OWNER_BITS   = 8;
   localparam int FREED_W      = $clog2(MAX_REGIONS + 1);
   localparam int QUIET_CYCLES = 2 * MAX_REGIONS + 8;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 85;

   // codes the package leaves unnamed
   localparam logic [CMD_W-1:0]  CMD_UNUSED   = 2'd3;
   localparam logic [MODE_W-1:0] MODE_INVALID = 2'd3;

   typedef struct packed {
      logic                  ok;
      logic [STATUS_W-1:0]   status;
      logic [ADDR_BITS-1:0]  base;
      logic [FREED_W-1:0]    freed;
   } alloc_rsp_type;

   // shadow of the region table plus the queue of responses still owed by the block
   class region_table_model;
      bit [AMT_W-1:0]      total;
      bit [ADDR_BITS-1:0]  base_q  [MAX_REGIONS];
      bit [AMT_W-1:0]      size_q  [MAX_REGIONS];
      bit [OWNER_BITS-1:0] owner_q [MAX_REGIONS];
      int                  count;
      alloc_rsp_type       awaited_responses[$];
      int                  mismatches;

      function new();
         total      = TOTAL_RESET;
         count      = 0;
         mismatches = 0;
      endfunction

      // total as the block sees it: clamped to the address span
      function bit [31:0] usable_total();
         bit [31:0] span_top;
         span_top = 32'd1 << ADDR_BITS;
         return (32'(total) > span_top) ? span_top : 32'(total);
      endfunction

      function bit [31:0] hole_begin(int i);
         if (i == 0) return 0;
         return 32'(base_q[i-1]) + 32'(size_q[i-1]);
      endfunction

      // a hole whose end lies below its start is empty
      function bit [31:0] hole_len(int i);
         bit [31:0] s, e;
         s = hole_begin(i);
         e = (i == count) ? usable_total() : 32'(base_q[i]);
         return (e > s) ? e - s : 0;
      endfunction

      // index of the chosen hole, or -1 when none will do
      function int choose_hole(bit [MODE_W-1:0] mode, bit [AMT_W-1:0] amount);
         int        pick, i;
         bit [31:0] best, len;
         pick = -1;
         best = 0;
         for (i = 0; i <= count; i++) begin
            len = hole_len(i);
            if (mode == MODE_FIRST) begin
               if (len >= amount) return i;
            end else if (mode == MODE_BEST) begin
               if (len >= amount && (pick < 0 || len < best)) begin
                  pick = i;
                  best = len;
               end
            end else if (pick < 0 || len > best) begin
               pick = i;
               best = len;
            end
         end
         if (mode == MODE_WORST && (pick < 0 || best < amount)) return -1;
         return pick;
      endfunction

      // updates the shadow table and gives the response the block owes
      function alloc_rsp_type apply_command(bit [CMD_W-1:0] cmd, bit [OWNER_BITS-1:0] owner,
                                            bit [AMT_W-1:0] amount, bit [MODE_W-1:0] mode);
         alloc_rsp_type r;
         int            hole, j, w;
         bit [31:0]     at, run;
         r        = '0;
         r.status = ST_DONE;
         case (cmd)
            CMD_ALLOC: begin
               if (mode > MODE_WORST) r.status = ST_BADMODE;
               else if (count >= MAX_REGIONS) r.status = ST_FULL;
               else if (amount == 0) r.status = ST_NOFIT;
               else begin
                  hole = choose_hole(mode, amount);
                  if (hole < 0) r.status = ST_NOFIT;
                  else begin
                     at = hole_begin(hole);
                     for (j = count; j > hole; j--) begin
                        base_q[j]  = base_q[j-1];
                        size_q[j]  = size_q[j-1];
                        owner_q[j] = owner_q[j-1];
                     end
                     base_q[hole]  = at[ADDR_BITS-1:0];
                     size_q[hole]  = amount;
                     owner_q[hole] = owner;
                     count++;
                     r.ok   = 1'b1;
                     r.base = at[ADDR_BITS-1:0];
                  end
               end
            end
            CMD_RELEASE: begin
               w = 0;
               for (j = 0; j < count; j++) begin
                  if (owner_q[j] == owner) r.freed++;
                  else begin
                     base_q[w]  = base_q[j];
                     size_q[w]  = size_q[j];
                     owner_q[w] = owner_q[j];
                     w++;
                  end
               end
               count = w;
               if (r.freed != 0) r.ok = 1'b1;
               else r.status = ST_NOOWNER;
            end
            CMD_COMPACT: begin
               run = 0;
               for (j = 0; j < count; j++) begin
                  base_q[j] = run[ADDR_BITS-1:0];
                  run += 32'(size_q[j]);
               end
               r.ok = 1'b1;
            end
            default: r.status = ST_BADMODE;
         endcase
         return r;
      endfunction

      function void note_request(bit [CMD_W-1:0] cmd, bit [OWNER_BITS-1:0] owner,
                                 bit [AMT_W-1:0] amount, bit [MODE_W-1:0] mode);
         awaited_responses.push_back(apply_command(cmd, owner, amount, mode));
      endfunction

      function int outstanding();
         return awaited_responses.size();
      endfunction

      task report_mismatch(string what, longint got, longint want);
         $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
         mismatches++;
      endtask

      task check_response(alloc_rsp_type got);
         alloc_rsp_type want;
         if (awaited_responses.size() == 0) begin
            report_mismatch("response with nothing outstanding, status",
                            longint'(got.status), longint'(-1));
         end else begin
            want = awaited_responses.pop_front();
            if (got.ok !== want.ok)
               report_mismatch("ok", longint'(got.ok), longint'(want.ok));
            if (got.status !== want.status)
               report_mismatch("status", longint'(got.status), longint'(want.status));
            if (got.base !== want.base)
               report_mismatch("granted_base", longint'(got.base), longint'(want.base));
            if (got.freed !== want.freed)
               report_mismatch("freed_count", longint'(got.freed), longint'(want.freed));
         end
      endtask

      task flush_missing();
         alloc_rsp_type want;
         while (awaited_responses.size() != 0) begin
            want = awaited_responses.pop_front();
            report_mismatch("response never delivered, status", longint'(-1),
                            longint'(want.status));
         end
      endtask
   endclass

   // clock, reset and block inputs all start known
   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       csr_wr_en   = 1'b0;
   logic [AMT_W-1:0]           csr_wr_data = '0;
   logic                       req_valid   = 1'b0;
   logic                       req_stall;
   logic [CMD_W-1:0]           req_cmd      = CMD_COMPACT;
   logic [OWNER_BITS-1:0]      req_owner_id = '0;
   logic [AMT_W-1:0]           req_amount   = '0;
   logic [MODE_W-1:0]          req_fit_mode = MODE_FIRST;
   logic                       rsp_valid;
   logic                       rsp_stall   = 1'b0;
   logic                       rsp_ok;
   logic [STATUS_W-1:0]        rsp_status;
   logic [ADDR_BITS-1:0]       rsp_granted_base;
   logic [FREED_W-1:0]         rsp_freed_count;

   region_table_model book;

   always #2 clock = ~clock;

   contiguous_fit_allocator #(
      .MAX_REGIONS (MAX_REGIONS),
      .ADDR_BITS   (ADDR_BITS),
      .OWNER_BITS  (OWNER_BITS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_owner_id     (req_owner_id),
      .req_amount       (req_amount),
      .req_fit_mode     (req_fit_mode),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ok           (rsp_ok),
      .rsp_status       (rsp_status),
      .rsp_granted_base (rsp_granted_base),
      .rsp_freed_count  (rsp_freed_count)
   );

   // offer one request and hold it until the block takes it; called just after a rising edge
   task automatic send_request(logic [CMD_W-1:0] cmd, logic [OWNER_BITS-1:0] owner,
                               logic [AMT_W-1:0] amount, logic [MODE_W-1:0] mode);
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_owner_id <= owner;
      req_amount   <= amount;
      req_fit_mode <= mode;
      do @(posedge clock); while (req_stall);
      book.note_request(cmd, owner, amount, mode);
   endtask

   // gap between bursts; a zero gap keeps valid high straight into the next request
   task automatic idle_sender(int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // hold back until every owed response has come, then let the sequencer settle
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (book.outstanding() > 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // only ever called with the block quiet
   task automatic write_total(logic [AMT_W-1:0] value);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      book.total = value;
   endtask

   // one random request shaped by the current total and the spread of owners in play
   task automatic random_request(int owner_span);
      int                    roll, scale;
      logic [CMD_W-1:0]      cmd;
      logic [OWNER_BITS-1:0] owner;
      logic [AMT_W-1:0]      amount;
      logic [MODE_W-1:0]     mode;
      roll   = $urandom_range(0, 99);
      scale  = book.usable_total() / 5;
      if (scale < 1) scale = 1;
      owner  = OWNER_BITS'($urandom_range(0, owner_span));
      amount = AMT_W'($urandom_range(1, scale));
      mode   = MODE_W'($urandom_range(0, 2));
      cmd    = CMD_ALLOC;
      if (roll < 55) begin
         // allocations, now and then a zero or a huge size
         if ($urandom_range(0, 19) == 0) amount = '0;
         else if ($urandom_range(0, 19) == 0) amount = AMT_W'($urandom_range(0, 21'h1F_FFFF));
      end else if (roll < 75) begin
         cmd = CMD_RELEASE;
      end else if (roll < 85) begin
         cmd = CMD_COMPACT;
      end else if (roll < 90) begin
         // unknown command or bad fit mode
         if ($urandom_range(0, 1) == 0) cmd = CMD_UNUSED;
         else mode = MODE_INVALID;
      end else begin
         // anything the fields allow
         cmd    = CMD_W'($urandom_range(0, 3));
         owner  = OWNER_BITS'($urandom_range(0, 255));
         amount = AMT_W'($urandom_range(0, 21'h1F_FFFF));
         mode   = MODE_W'($urandom_range(0, 3));
      end
      send_request(cmd, owner, amount, mode);
   endtask

   // response checker: a response moves at an edge with valid high and stall low
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         book.check_response({rsp_ok, rsp_status, rsp_granted_base, rsp_freed_count});
   end

   // receiver stall pattern: clear runs, light and heavy random stalls, a fixed rhythm,
   // and long hold-offs that back the block up into its request side
   initial begin : response_sink
      int seg, span, roll, k;
      seg = 0;
      forever begin
         roll = $urandom_range(0, 9);
         if (seg == 3 || (roll == 9 && $urandom_range(0, 2) == 0)) begin
            // long hold-off, the sender keeps offering meanwhile
            span = $urandom_range(150, 300);
            for (k = 0; k < span; k++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end else begin
            span = $urandom_range(20, 80);
            for (k = 0; k < span; k++) begin
               if (roll < 3) rsp_stall <= 1'b0;
               else if (roll < 6) rsp_stall <= ($urandom_range(0, 2) == 0);
               else if (roll < 8) rsp_stall <= (k % 3 == 0);
               else rsp_stall <= ($urandom_range(0, 9) < 7);
               @(posedge clock);
            end
         end
         seg++;
      end
   end

   // main sequence: reset, directed requests, then phases with different totals
   initial begin : stimulus
      int p, i, n, burst_left, owner_span;
      logic [AMT_W-1:0] phase_total;
      book = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: rejects, empty table, whole-region grant, fit choices, compaction
      send_request(CMD_ALLOC,   8'd0,   21'd0,       MODE_FIRST);   // zero amount
      send_request(CMD_ALLOC,   8'd1,   21'd10,      MODE_INVALID); // bad fit mode
      send_request(CMD_UNUSED,  8'd1,   21'd10,      MODE_FIRST);   // unknown command
      send_request(CMD_RELEASE, 8'd9,   21'd0,       MODE_FIRST);   // owner not present
      send_request(CMD_COMPACT, 8'd0,   21'd0,       MODE_FIRST);   // compaction of nothing
      send_request(CMD_ALLOC,   8'd255, 21'd1048576, MODE_FIRST);   // whole region
      send_request(CMD_ALLOC,   8'd1,   21'd1,       MODE_BEST);    // nothing left
      send_request(CMD_ALLOC,   8'd1,   21'h1F_FFFF, MODE_WORST);   // largest amount
      send_request(CMD_RELEASE, 8'd255, 21'd0,       MODE_FIRST);
      send_request(CMD_ALLOC,   8'd1,   21'd100,     MODE_FIRST);
      send_request(CMD_ALLOC,   8'd2,   21'd50,      MODE_FIRST);
      send_request(CMD_ALLOC,   8'd3,   21'd200,     MODE_FIRST);
      send_request(CMD_ALLOC,   8'd2,   21'd40,      MODE_FIRST);
      send_request(CMD_RELEASE, 8'd2,   21'd0,       MODE_FIRST);   // two regions at once
      send_request(CMD_ALLOC,   8'd4,   21'd30,      MODE_BEST);    // small gap beats the tail
      send_request(CMD_ALLOC,   8'd5,   21'd20,      MODE_WORST);   // tail is largest
      send_request(CMD_ALLOC,   8'd6,   21'd20,      MODE_FIRST);
      send_request(CMD_ALLOC,   8'd7,   21'd20,      MODE_BEST);
      send_request(CMD_COMPACT, 8'd0,   21'd0,       MODE_BEST);
      send_request(CMD_ALLOC,   8'd8,   21'd1048576, MODE_WORST);   // too big after all
      send_request(CMD_RELEASE, 8'd170, 21'd0,       MODE_WORST);
      send_request(CMD_ALLOC,   8'd85,  21'h0A_AAAA, MODE_FIRST);
      wait_quiet();

      // random phases; totals shrink below live regions, hit zero, one and the clamp
      burst_left = 0;
      for (p = 0; p < PHASES; p++) begin
         case (p)
            0:       begin phase_total = 21'd1048576; owner_span = 7;   end
            1:       begin phase_total = 21'd160;     owner_span = 5;   end
            2:       begin phase_total = 21'd0;       owner_span = 3;   end
            3:       begin phase_total = 21'd48;      owner_span = 0;   end
            4:       begin phase_total = 21'h1F_FFFF; owner_span = 7;   end
            5:       begin phase_total = 21'd1;       owner_span = 1;   end
            6:       begin phase_total = 21'd400;     owner_span = 15;  end
            7:       begin phase_total = 21'd24;      owner_span = 1;   end
            8:       begin phase_total = 21'd1048576; owner_span = 255; end
            default: begin phase_total = 21'd96;      owner_span = 3;   end
         endcase
         if (p > 0) write_total(phase_total);
         for (i = 0; i < PHASE_ITEMS; i++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               idle_sender($urandom_range(0, 6));
            end
            burst_left--;
            random_request(owner_span);
            // now and then let the block drain completely mid-phase
            if ($urandom_range(0, 59) == 0) wait_quiet();
         end
         wait_quiet();
      end

      // bounded wait for stragglers, then the verdict
      req_valid <= 1'b0;
      for (n = 0; n < 20000 && book.outstanding() > 0; n++) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
      book.flush_missing();
      if (book.mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin : watchdog
      #5000000;
      $display("simulation failed");
      $finish;
   end

endmodule
